### rtl/vtesc_pkg.sv
// Shared types, command codes, byte codes and helpers for the VT escape parser.
`default_nettype none

package vtesc_pkg;

    // Parameter store geometry
    localparam int MAX_PARAMS = 8;
    localparam int PARAM_BITS = 16;
    localparam int PCOUNT_W   = $clog2(MAX_PARAMS + 1);
    localparam int PIDX_W     = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    typedef logic [PARAM_BITS-1:0] param_t;
    typedef logic [PCOUNT_W-1:0]   pcount_t;
    typedef logic [PIDX_W-1:0]     pidx_t;

    // Display command codes
    localparam logic [3:0] CMD_PUT_CHAR      = 4'd0;
    localparam logic [3:0] CMD_CR            = 4'd1;
    localparam logic [3:0] CMD_NEWLINE       = 4'd2;
    localparam logic [3:0] CMD_BACK          = 4'd3;
    localparam logic [3:0] CMD_FORWARD       = 4'd4;
    localparam logic [3:0] CMD_UP            = 4'd5;
    localparam logic [3:0] CMD_DOWN          = 4'd6;
    localparam logic [3:0] CMD_ERASE_DISPLAY = 4'd7;
    localparam logic [3:0] CMD_ERASE_LINE    = 4'd8;
    localparam logic [3:0] CMD_SET_COLOR     = 4'd9;

    // Erase modes
    localparam logic [1:0] ERASE_TO_END   = 2'd0;
    localparam logic [1:0] ERASE_TO_START = 2'd1;
    localparam logic [1:0] ERASE_WHOLE    = 2'd2;

    // Byte codes
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_QUEST    = 8'h3F;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] FINAL_LO    = 8'h40;
    localparam logic [7:0] FINAL_HI    = 8'h7E;
    localparam logic [7:0] FIN_UP      = 8'h41;
    localparam logic [7:0] FIN_DOWN    = 8'h42;
    localparam logic [7:0] FIN_FORWARD = 8'h43;
    localparam logic [7:0] FIN_BACK    = 8'h44;
    localparam logic [7:0] FIN_ED      = 8'h4A;
    localparam logic [7:0] FIN_EL      = 8'h4B;
    localparam logic [7:0] FIN_SGR     = 8'h6D;

    // Colors
    localparam logic [4:0] COLOR_DEFAULT = 5'd16;
    localparam logic [4:0] TAB_RESET     = 5'd8;

    // Decoded result of one item
    typedef struct packed {
        logic        emit;
        logic [3:0]  cmd;
        logic [20:0] code_point;
        logic [15:0] move_count;
        logic [1:0]  erase_mode;
    } result_t;

    // Cursor move distance: zero means one, large values clip to 16 bits
    function automatic logic [15:0] move_dist(input param_t p);
        logic [PARAM_BITS+15:0] w;
        w = {{16{1'b0}}, p};
        if (p == '0)
            move_dist = 16'd1;
        else if (w > (PARAM_BITS + 16)'(17'h0FFFF))
            move_dist = 16'hFFFF;
        else
            move_dist = w[15:0];
    endfunction

endpackage

`default_nettype wire

### rtl/vtesc_text.sv
// Plain text decoder: control bytes and UTF-8 assembly.
`default_nettype none

module vtesc_text (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             active,
    input  wire logic [7:0]       byte_in,
    input  wire logic [7:0]       tab_width,
    output vtesc_pkg::result_t    res,
    output logic                  esc_seen
);
    import vtesc_pkg::*;

    logic [20:0] accum_reg, accum_next;
    logic [1:0]  remain_reg, remain_next;
    logic [1:0]  length_reg, length_next;

    logic        is_cont;
    logic [20:0] cp;
    logic        cp_ok;

    always_comb
    begin
        is_cont     = (byte_in[7:6] == 2'b10);
        cp          = {accum_reg[14:0], byte_in[5:0]};
        cp_ok       = 1'b0;
        accum_next  = accum_reg;
        remain_next = remain_reg;
        length_next = length_reg;
        res         = '0;
        esc_seen    = 1'b0;

        if (remain_reg != 2'd0 && is_cont)
        begin
            // continuation byte of a pending character
            accum_next  = cp;
            remain_next = remain_reg - 2'd1;
            if (remain_reg == 2'd1)
            begin
                case (length_reg)
                    2'd1:    cp_ok = (cp >= 21'h80);
                    2'd2:    cp_ok = (cp >= 21'h800) && ((cp < 21'hD800) || (cp > 21'hDFFF));
                    default: cp_ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
                endcase
                accum_next      = '0;
                length_next     = 2'd0;
                res.emit        = cp_ok;
                res.cmd         = CMD_PUT_CHAR;
                res.code_point  = cp_ok ? cp : 21'd0;
            end
        end
        else
        begin
            // a partial character is dropped; the byte starts afresh
            accum_next  = '0;
            remain_next = 2'd0;
            length_next = 2'd0;
            if (byte_in == CH_ESC)
                esc_seen = 1'b1;
            else if (byte_in == CH_CR)
            begin
                res.emit = 1'b1;
                res.cmd  = CMD_CR;
            end
            else if (byte_in == CH_LF)
            begin
                res.emit = 1'b1;
                res.cmd  = CMD_NEWLINE;
            end
            else if (byte_in == CH_BS)
            begin
                res.emit       = 1'b1;
                res.cmd        = CMD_BACK;
                res.move_count = 16'd1;
            end
            else if (byte_in == CH_TAB)
            begin
                res.emit       = 1'b1;
                res.cmd        = CMD_FORWARD;
                res.move_count = (tab_width == 8'd0) ? 16'd1 : {8'd0, tab_width};
            end
            else if (byte_in < CH_SPACE || byte_in == CH_DEL)
                res.emit = 1'b0;
            else if (byte_in[7] == 1'b0)
            begin
                res.emit       = 1'b1;
                res.cmd        = CMD_PUT_CHAR;
                res.code_point = {13'd0, byte_in};
            end
            else if (byte_in >= 8'hC2 && byte_in <= 8'hDF)
            begin
                accum_next  = {16'd0, byte_in[4:0]};
                remain_next = 2'd1;
                length_next = 2'd1;
            end
            else if (byte_in >= 8'hE0 && byte_in <= 8'hEF)
            begin
                accum_next  = {17'd0, byte_in[3:0]};
                remain_next = 2'd2;
                length_next = 2'd2;
            end
            else if (byte_in >= 8'hF0 && byte_in <= 8'hF4)
            begin
                accum_next  = {18'd0, byte_in[2:0]};
                remain_next = 2'd3;
                length_next = 2'd3;
            end
        end
    end

    // UTF-8 state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg  <= '0;
            remain_reg <= 2'd0;
            length_reg <= 2'd0;
        end
        else if (active)
        begin
            accum_reg  <= accum_next;
            remain_reg <= remain_next;
            length_reg <= length_next;
        end
    end

endmodule

`default_nettype wire

### rtl/vtesc_csi.sv
// Escape and CSI sequence tracker with parameter store and SGR color.
`default_nettype none

module vtesc_csi (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       byte_in,
    input  wire logic             esc_seen,
    output logic                  in_text,
    output vtesc_pkg::result_t    res,
    output logic [4:0]            color_next
);
    import vtesc_pkg::*;

    localparam logic [1:0] PH_PLAIN = 2'd0;
    localparam logic [1:0] PH_ESC   = 2'd1;
    localparam logic [1:0] PH_CSI   = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    param_t      params_reg [MAX_PARAMS];
    param_t      params_next [MAX_PARAMS];
    pcount_t     count_reg, count_next;
    logic [4:0]  color_reg;

    pcount_t                count_eff;
    pidx_t                  widx;
    logic [PARAM_BITS+3:0]  prod;
    logic [PARAM_BITS+3:0]  pmax_w;
    pcount_t                sgr_n;
    param_t                 p;
    logic [4:0]             col;

    assign in_text = (phase_reg == PH_PLAIN);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        params_next = params_reg;
        color_next  = color_reg;
        res         = '0;
        count_eff   = (count_reg == '0) ? pcount_t'(1) : count_reg;
        widx        = pidx_t'(count_eff - pcount_t'(1));
        pmax_w      = {4'd0, {PARAM_BITS{1'b1}}};
        prod        = ({4'd0, params_reg[widx]} << 3) + ({4'd0, params_reg[widx]} << 1)
                      + (PARAM_BITS + 4)'(byte_in[3:0]);
        sgr_n       = count_eff;
        col         = color_reg;
        p           = '0;

        unique case (phase_reg)
            PH_PLAIN:
            begin
                if (esc_seen)
                    phase_next = PH_ESC;
            end
            PH_ESC:
            begin
                if (byte_in == CH_LBRACKET)
                begin
                    phase_next = PH_CSI;
                    count_next = '0;
                    for (int i = 0; i < MAX_PARAMS; i++)
                        params_next[i] = '0;
                end
                else
                    phase_next = PH_PLAIN;
            end
            PH_CSI:
            begin
                if (byte_in >= CH_ZERO && byte_in <= CH_NINE)
                begin
                    // decimal digit into the last parameter, saturating
                    count_next        = count_eff;
                    params_next[widx] = (prod > pmax_w) ? {PARAM_BITS{1'b1}}
                                                        : prod[PARAM_BITS-1:0];
                end
                else if (byte_in == CH_SEMI)
                begin
                    count_next = count_eff;
                    if (count_eff < pcount_t'(MAX_PARAMS))
                    begin
                        params_next[pidx_t'(count_eff)] = '0;
                        count_next = count_eff + pcount_t'(1);
                    end
                end
                else if (byte_in >= FINAL_LO && byte_in <= FINAL_HI)
                begin
                    phase_next = PH_PLAIN;
                    case (byte_in)
                        FIN_UP, FIN_DOWN, FIN_FORWARD, FIN_BACK:
                        begin
                            res.emit       = 1'b1;
                            res.cmd        = (byte_in == FIN_UP)      ? CMD_UP :
                                             (byte_in == FIN_DOWN)    ? CMD_DOWN :
                                             (byte_in == FIN_FORWARD) ? CMD_FORWARD : CMD_BACK;
                            res.move_count = move_dist((count_reg != '0) ? params_reg[0] : '0);
                        end
                        FIN_ED:
                        begin
                            res.emit       = 1'b1;
                            res.cmd        = CMD_ERASE_DISPLAY;
                            res.erase_mode = (count_reg == pcount_t'(1) &&
                                              params_reg[0] == PARAM_BITS'(2))
                                             ? ERASE_WHOLE : ERASE_TO_END;
                        end
                        FIN_EL:
                        begin
                            p              = (count_reg != '0) ? params_reg[0] : '0;
                            res.emit       = 1'b1;
                            res.cmd        = CMD_ERASE_LINE;
                            res.erase_mode = (p == '0) ? ERASE_TO_END :
                                             (p == PARAM_BITS'(1)) ? ERASE_TO_START
                                                                   : ERASE_WHOLE;
                        end
                        FIN_SGR:
                        begin
                            // apply each parameter in order; the last match wins
                            for (int i = 0; i < MAX_PARAMS; i++)
                            begin
                                if (i < int'(sgr_n))
                                begin
                                    p = (i < int'(count_reg)) ? params_reg[i] : '0;
                                    if (p == '0 || p == PARAM_BITS'(39))
                                        col = COLOR_DEFAULT;
                                    else if (p >= PARAM_BITS'(30) && p <= PARAM_BITS'(37))
                                        col = 5'(p - PARAM_BITS'(30));
                                    else if (p >= PARAM_BITS'(90) && p <= PARAM_BITS'(97))
                                        col = 5'(p - PARAM_BITS'(82));
                                end
                            end
                            color_next = col;
                            res.emit   = 1'b1;
                            res.cmd    = CMD_SET_COLOR;
                        end
                        default: res.emit = 1'b0;
                    endcase
                end
                else if (byte_in != CH_QUEST && byte_in != CH_SPACE)
                    phase_next = PH_PLAIN;
            end
            default: phase_next = PH_PLAIN;
        endcase

        if (!fire)
            color_next = color_reg;
    end

    // Sequence control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PLAIN;
            count_reg <= '0;
            color_reg <= COLOR_DEFAULT;
            for (int i = 0; i < MAX_PARAMS; i++)
                params_reg[i] <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            color_reg  <= color_next;
            params_reg <= params_next;
        end
    end

endmodule

`default_nettype wire

### rtl/vt_escape_sequence_parser.sv
// Top level of the VT escape sequence parser: input register, decode, result register.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------------
//  in       | in_valid / in_ready     | byte_in
//  out      | out_valid / out_ready   | cmd, code_point, move_count, erase_mode, color
//  cfg      | cfg_we                  | cfg_data (tab_width)
//
// One byte per cycle sustained while no result waits; each byte is held in the input register
// and its result is written into the result register when the byte advances.
// The decode of a held byte (UTF-8, CSI digit accumulate, SGR color scan) is one
// combinational pass between the two registers.
// A byte that produces a result waits while the result register is full and not taken;
// bytes that produce none pass regardless. Reset clears sequence, color and UTF-8 state
// and sets tab width to 8.
`default_nettype none

module vt_escape_sequence_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       cmd,
    output logic [20:0]      code_point,
    output logic [15:0]      move_count,
    output logic [1:0]       erase_mode,
    output logic [4:0]       color,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_data
);
    import vtesc_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  tab_width_reg;
    logic        out_valid_reg;
    logic [3:0]  cmd_reg;
    logic [20:0] code_point_reg;
    logic [15:0] move_count_reg;
    logic [1:0]  erase_mode_reg;
    logic [4:0]  color_reg;

    result_t     text_res;
    result_t     csi_res;
    result_t     res;
    logic        esc_seen;
    logic        in_text;
    logic        fire;
    logic [4:0]  color_next;

    vtesc_text u_text (
        .clk       (clk),
        .rst_n     (rst_n),
        .active    (fire && in_text),
        .byte_in   (byte_reg),
        .tab_width (tab_width_reg),
        .res       (text_res),
        .esc_seen  (esc_seen)
    );

    vtesc_csi u_csi (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .byte_in    (byte_reg),
        .esc_seen   (esc_seen && in_text),
        .in_text    (in_text),
        .res        (csi_res),
        .color_next (color_next)
    );

    // Result selection and advance condition
    assign res      = in_text ? text_res : csi_res;
    assign fire     = in_valid_reg && (!res.emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= byte_in;
    end

    // Tab width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tab_width_reg <= {3'd0, TAB_RESET};
        else if (cfg_we)
            tab_width_reg <= cfg_data;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && res.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.emit)
        begin
            cmd_reg        <= res.cmd;
            code_point_reg <= res.code_point;
            move_count_reg <= res.move_count;
            erase_mode_reg <= res.erase_mode;
            color_reg      <= color_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cmd        = cmd_reg;
    assign code_point = code_point_reg;
    assign move_count = move_count_reg;
    assign erase_mode = erase_mode_reg;
    assign color      = color_reg;

    // Checks
    a_cp_only_put: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmd != CMD_PUT_CHAR |-> code_point == 21'd0)
        else $error("code point on a non-character command");

    a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmd == CMD_PUT_CHAR |-> code_point <= 21'h10FFFF
                                             && move_count == 16'd0)
        else $error("character result out of range");

    a_move_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cmd == CMD_BACK || cmd == CMD_FORWARD || cmd == CMD_UP
                      || cmd == CMD_DOWN) |-> move_count != 16'd0)
        else $error("cursor move of zero");

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pending result dropped");

endmodule

`default_nettype wire

### sim/vt_escape_sequence_parser_tb.sv
// Self-checking testbench for the VT escape sequence parser.
`default_nettype none

module vt_escape_sequence_parser_tb;
    import vtesc_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 60;
    localparam int LIMIT_CYCLES = 200000;

    // Parser phases
    localparam logic [1:0] PH_PLAIN = 2'd0;
    localparam logic [1:0] PH_ESC   = 2'd1;
    localparam logic [1:0] PH_CSI   = 2'd2;

    // SGR parameter values
    localparam int unsigned SGR_RESET     = 0;
    localparam int unsigned SGR_FG_LO     = 30;
    localparam int unsigned SGR_FG_HI     = 37;
    localparam int unsigned SGR_FG_DEF    = 39;
    localparam int unsigned SGR_BRIGHT_LO = 90;
    localparam int unsigned SGR_BRIGHT_HI = 97;

    // UTF-8 lead byte ranges and code point limits
    localparam logic [7:0]  U8_CONT    = 8'h80;
    localparam logic [7:0]  U8_L2_LO   = 8'hC2;
    localparam logic [7:0]  U8_L2_HI   = 8'hDF;
    localparam logic [7:0]  U8_L3_LO   = 8'hE0;
    localparam logic [7:0]  U8_L3_HI   = 8'hEF;
    localparam logic [7:0]  U8_L4_LO   = 8'hF0;
    localparam logic [7:0]  U8_L4_HI   = 8'hF4;
    localparam int unsigned CP_MIN2    = 'h80;
    localparam int unsigned CP_MIN3    = 'h800;
    localparam int unsigned CP_MIN4    = 'h10000;
    localparam int unsigned CP_MAX     = 'h10FFFF;
    localparam int unsigned SURR_LO    = 'hD800;
    localparam int unsigned SURR_HI    = 'hDFFF;
    localparam int unsigned PMAX       = (1 << PARAM_BITS) - 1;
    localparam int unsigned COUNT_MAX  = 65535;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [20:0] code_point;
        logic [15:0] move_count;
        logic [1:0]  erase_mode;
        logic [4:0]  color;
    } disp_cmd_t;

    // DUT signals
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_in  = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  cmd;
    logic [20:0] code_point;
    logic [15:0] move_count;
    logic [1:0]  erase_mode;
    logic [4:0]  color;
    logic        cfg_we   = 1'b0;
    logic [7:0]  cfg_data = 8'h00;

    // Stimulus and expectation stores
    logic [7:0] tx_bytes[$];
    disp_cmd_t  due_cmds[$];

    // Shared run control
    bit  idle_on     = 1'b1;
    int  hold_req    = 0;
    int  hold_served = 0;
    int  hold_left   = 0;
    int  send_gap    = 0;
    int  err_count   = 0;
    int  n_bytes     = 0;
    int  n_cmds      = 0;

    // Predictor state
    logic [1:0]  phase     = PH_PLAIN;
    int unsigned pvals[MAX_PARAMS];
    int          pcnt      = 0;
    logic [4:0]  cur_color = COLOR_DEFAULT;
    logic [20:0] uacc      = '0;
    int          urem      = 0;
    int          ulen      = 0;
    logic [7:0]  tab_w     = 8'd8;

    vt_escape_sequence_parser u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .code_point (code_point),
        .move_count (move_count),
        .erase_mode (erase_mode),
        .color      (color),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic push_cmd(input logic [3:0] c, input int unsigned cp,
                            input int unsigned cnt, input logic [1:0] mode);
        disp_cmd_t d;
        d.cmd        = c;
        d.code_point = cp[20:0];
        d.move_count = (cnt > COUNT_MAX) ? 16'hFFFF : cnt[15:0];
        d.erase_mode = mode;
        d.color      = cur_color;
        due_cmds.push_back(d);
    endtask

    // Parameter idx, or dflt when absent or zero
    function automatic int unsigned csi_arg(input int idx, input int unsigned dflt);
        if (idx < pcnt && idx < MAX_PARAMS && pvals[idx] != 0)
            return pvals[idx];
        return dflt;
    endfunction

    task automatic apply_final(input logic [7:0] b);
        int unsigned p;
        int          n;
        case (b)
            FIN_UP:      push_cmd(CMD_UP, 0, csi_arg(0, 1), ERASE_TO_END);
            FIN_DOWN:    push_cmd(CMD_DOWN, 0, csi_arg(0, 1), ERASE_TO_END);
            FIN_FORWARD: push_cmd(CMD_FORWARD, 0, csi_arg(0, 1), ERASE_TO_END);
            FIN_BACK:    push_cmd(CMD_BACK, 0, csi_arg(0, 1), ERASE_TO_END);
            FIN_ED:
            begin
                push_cmd(CMD_ERASE_DISPLAY, 0, 0,
                         (pcnt == 1 && pvals[0] == 2) ? ERASE_WHOLE : ERASE_TO_END);
            end
            FIN_EL:
            begin
                p = (pcnt != 0) ? pvals[0] : 0;
                push_cmd(CMD_ERASE_LINE, 0, 0,
                         (p == 0) ? ERASE_TO_END : ((p == 1) ? ERASE_TO_START : ERASE_WHOLE));
            end
            FIN_SGR:
            begin
                n = (pcnt != 0) ? pcnt : 1;
                for (int i = 0; i < n && i < MAX_PARAMS; i++)
                begin
                    p = csi_arg(i, 0);
                    if (p == SGR_RESET || p == SGR_FG_DEF)
                        cur_color = COLOR_DEFAULT;
                    else if (p >= SGR_FG_LO && p <= SGR_FG_HI)
                        cur_color = 5'(p - SGR_FG_LO);
                    else if (p >= SGR_BRIGHT_LO && p <= SGR_BRIGHT_HI)
                        cur_color = 5'(p - SGR_BRIGHT_LO + 8);
                end
                push_cmd(CMD_SET_COLOR, 0, 0, ERASE_TO_END);
            end
            default: ;
        endcase
    endtask

    task automatic text_byte(input logic [7:0] b);
        int unsigned cp;
        logic        ok;
        // continuation of a pending UTF-8 character
        if (urem > 0)
        begin
            if (b[7:6] == 2'b10)
            begin
                uacc = {uacc[14:0], b[5:0]};
                urem--;
                if (urem != 0)
                    return;
                cp = uacc;
                if (ulen == 1)
                    ok = cp >= CP_MIN2;
                else if (ulen == 2)
                    ok = cp >= CP_MIN3 && (cp < SURR_LO || cp > SURR_HI);
                else
                    ok = cp >= CP_MIN4 && cp <= CP_MAX;
                uacc = '0;
                ulen = 0;
                if (ok)
                    push_cmd(CMD_PUT_CHAR, cp, 0, ERASE_TO_END);
                return;
            end
            // partial character dropped, byte handled afresh
            uacc = '0;
            urem = 0;
            ulen = 0;
        end
        if (b == CH_ESC)
            phase = PH_ESC;
        else if (b == CH_CR)
            push_cmd(CMD_CR, 0, 0, ERASE_TO_END);
        else if (b == CH_LF)
            push_cmd(CMD_NEWLINE, 0, 0, ERASE_TO_END);
        else if (b == CH_BS)
            push_cmd(CMD_BACK, 0, 1, ERASE_TO_END);
        else if (b == CH_TAB)
            push_cmd(CMD_FORWARD, 0, (tab_w != 0) ? tab_w : 1, ERASE_TO_END);
        else if (b < CH_SPACE || b == CH_DEL)
            ;
        else if (b < U8_CONT)
            push_cmd(CMD_PUT_CHAR, b, 0, ERASE_TO_END);
        else if (b >= U8_L2_LO && b <= U8_L2_HI)
        begin
            uacc = 21'(b[4:0]);
            urem = 1;
            ulen = 1;
        end
        else if (b >= U8_L3_LO && b <= U8_L3_HI)
        begin
            uacc = 21'(b[3:0]);
            urem = 2;
            ulen = 2;
        end
        else if (b >= U8_L4_LO && b <= U8_L4_HI)
        begin
            uacc = 21'(b[2:0]);
            urem = 3;
            ulen = 3;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int unsigned v;
        case (phase)
            PH_ESC:
            begin
                if (b == CH_LBRACKET)
                begin
                    phase = PH_CSI;
                    pcnt  = 0;
                    foreach (pvals[i]) pvals[i] = 0;
                end
                else
                    phase = PH_PLAIN;
            end
            PH_CSI:
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    if (pcnt == 0)
                        pcnt = 1;
                    v = pvals[pcnt-1] * 10 + (b - CH_ZERO);
                    pvals[pcnt-1] = (v > PMAX) ? PMAX : v;
                end
                else if (b == CH_SEMI)
                begin
                    if (pcnt == 0)
                        pcnt = 1;
                    if (pcnt < MAX_PARAMS)
                    begin
                        pvals[pcnt] = 0;
                        pcnt++;
                    end
                end
                else if (b >= FINAL_LO && b <= FINAL_HI)
                begin
                    phase = PH_PLAIN;
                    apply_final(b);
                end
                else if (b != CH_QUEST && b != CH_SPACE)
                    phase = PH_PLAIN;
            end
            PH_PLAIN: text_byte(b);
            default:  phase = PH_PLAIN;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued bytes, predicts on each accepted item
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(byte_in);
                n_bytes++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (idle_on && tx_bytes.size() > 0 && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(1, 6) - 1;
                    in_valid <= 1'b0;
                end
                else if (tx_bytes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    byte_in  <= tx_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result, drives ready with stalls
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        disp_cmd_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_cmds++;
                if (due_cmds.size() == 0)
                begin
                    $error("unexpected result: cmd %0d code_point %0h", cmd, code_point);
                    err_count++;
                end
                else
                begin
                    want = due_cmds.pop_front();
                    if (cmd !== want.cmd)
                    begin
                        $error("cmd: expected %0d, got %0d", want.cmd, cmd);
                        err_count++;
                    end
                    if (code_point !== want.code_point)
                    begin
                        $error("code_point: expected %0h, got %0h", want.code_point, code_point);
                        err_count++;
                    end
                    if (move_count !== want.move_count)
                    begin
                        $error("move_count: expected %0d, got %0d", want.move_count, move_count);
                        err_count++;
                    end
                    if (erase_mode !== want.erase_mode)
                    begin
                        $error("erase_mode: expected %0d, got %0d", want.erase_mode, erase_mode);
                        err_count++;
                    end
                    if (color !== want.color)
                    begin
                        $error("color: expected %0d, got %0d", want.color, color);
                        err_count++;
                    end
                end
            end
            // long hold-off on request, otherwise short random stalls when idling is on
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_served < hold_req)
            begin
                hold_served++;
                hold_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(1, 6) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            tx_bytes.push_back(s[i]);
    endtask

    task automatic put_csi(input string body);
        tx_bytes.push_back(CH_ESC);
        tx_bytes.push_back(CH_LBRACKET);
        put_str(body);
    endtask

    task automatic put_utf8(input int unsigned cp);
        if (cp < CP_MIN2)
            tx_bytes.push_back(cp[7:0]);
        else if (cp < CP_MIN3)
        begin
            tx_bytes.push_back(8'hC0 | cp[10:6]);
            tx_bytes.push_back(8'h80 | cp[5:0]);
        end
        else if (cp < CP_MIN4)
        begin
            tx_bytes.push_back(8'hE0 | cp[15:12]);
            tx_bytes.push_back(8'h80 | cp[11:6]);
            tx_bytes.push_back(8'h80 | cp[5:0]);
        end
        else
        begin
            tx_bytes.push_back(8'hF0 | cp[20:18]);
            tx_bytes.push_back(8'h80 | cp[17:12]);
            tx_bytes.push_back(8'h80 | cp[11:6]);
            tx_bytes.push_back(8'h80 | cp[5:0]);
        end
    endtask

    // Random CSI sequence: mixed parameter sizes, mostly known finals
    task automatic rand_csi();
        int          n;
        int          r;
        int unsigned v;
        tx_bytes.push_back(CH_ESC);
        tx_bytes.push_back(CH_LBRACKET);
        if ($urandom_range(0, 7) == 0)
            tx_bytes.push_back(($urandom_range(0, 1) != 0) ? CH_QUEST : CH_SPACE);
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                tx_bytes.push_back(CH_SEMI);
            r = $urandom_range(0, 5);
            case (r)
                0: v = 0;
                1: v = ($urandom_range(0, 1) != 0) ? SGR_FG_DEF : SGR_RESET;
                2: v = SGR_FG_LO + $urandom_range(0, 7);
                3: v = SGR_BRIGHT_LO + $urandom_range(0, 7);
                4: v = $urandom_range(0, 200);
                default: v = $urandom_range(0, 9999999);
            endcase
            if (r != 0 || $urandom_range(0, 1) != 0)
                put_str($sformatf("%0d", v));
        end
        r = $urandom_range(0, 15);
        case (r)
            0:  tx_bytes.push_back(FIN_UP);
            1:  tx_bytes.push_back(FIN_DOWN);
            2:  tx_bytes.push_back(FIN_FORWARD);
            3:  tx_bytes.push_back(FIN_BACK);
            4:  tx_bytes.push_back(FIN_ED);
            5:  tx_bytes.push_back(FIN_EL);
            11, 12: tx_bytes.push_back(8'($urandom_range(FINAL_LO, FINAL_HI)));
            13: tx_bytes.push_back(8'($urandom_range(8'h21, 8'h2F)));   // aborts
            14, 15: tx_bytes.push_back(8'($urandom_range(0, 255)));
            default: tx_bytes.push_back(FIN_SGR);
        endcase
    endtask

    // One random chunk of terminal output
    task automatic rand_chunk();
        int r;
        int n;
        r = $urandom_range(0, 19);
        if (r <= 4)
        begin
            n = $urandom_range(1, 4);
            repeat (n) tx_bytes.push_back(8'($urandom_range(CH_SPACE, FINAL_HI)));
        end
        else if (r <= 6)
        begin
            case ($urandom_range(0, 5))
                0: tx_bytes.push_back(CH_CR);
                1: tx_bytes.push_back(CH_LF);
                2: tx_bytes.push_back(CH_BS);
                3: tx_bytes.push_back(CH_TAB);
                4: tx_bytes.push_back(CH_DEL);
                default: tx_bytes.push_back(8'($urandom_range(0, 8'h1F)));
            endcase
        end
        else if (r <= 9)
        begin
            case ($urandom_range(2, 4))
                2: put_utf8($urandom_range(CP_MIN2, CP_MIN3 - 1));
                3: put_utf8($urandom_range(CP_MIN3, CP_MIN4 - 1));
                default: put_utf8($urandom_range(CP_MIN4, CP_MAX));
            endcase
        end
        else if (r == 10)
        begin
            // malformed UTF-8
            case ($urandom_range(0, 3))
                0:
                begin
                    tx_bytes.push_back(8'($urandom_range(U8_L2_LO, U8_L4_HI)));
                    tx_bytes.push_back(8'($urandom_range(CH_SPACE, FINAL_HI)));
                end
                1: tx_bytes.push_back(8'($urandom_range(U8_CONT, 8'hFF)));
                2:
                begin
                    tx_bytes.push_back(U8_L3_LO);
                    tx_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
                    tx_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                default:
                begin
                    tx_bytes.push_back(U8_L4_HI);
                    tx_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
                    tx_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                    tx_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
            endcase
        end
        else if (r <= 16)
            rand_csi();
        else if (r == 17)
        begin
            tx_bytes.push_back(CH_ESC);
            tx_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
            tx_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic run_random(input int nbytes);
        int start;
        start = tx_bytes.size();
        while (tx_bytes.size() - start < nbytes)
            rand_chunk();
    endtask

    // Sender pauses until everything queued is sent and every result is back;
    // sampled mid-cycle so driver updates of this edge are settled
    task automatic wait_drained();
        while (tx_bytes.size() != 0 || in_valid || due_cmds.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tab(input logic [7:0] w);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tab_w    = w;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] mid_tab;
        foreach (pvals[i]) pvals[i] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: plain bytes and controls, default tab width
        put_str("A ~");
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(CH_DEL);
        tx_bytes.push_back(CH_CR);
        tx_bytes.push_back(CH_LF);
        tx_bytes.push_back(CH_BS);
        tx_bytes.push_back(CH_TAB);
        // UTF-8 boundaries, then too large, surrogate, overlong, bad leads, strays
        put_utf8(CP_MIN2);
        put_utf8(CP_MIN3);
        put_utf8('h20AC);
        put_utf8(CP_MIN4);
        put_utf8(CP_MAX);
        put_utf8(CP_MAX + 1);
        put_utf8(SURR_LO);
        tx_bytes.push_back(U8_L3_LO); tx_bytes.push_back(8'h80); tx_bytes.push_back(8'h80);
        tx_bytes.push_back(8'hC0); tx_bytes.push_back(8'h80);
        tx_bytes.push_back(8'hC3); put_str("B");
        tx_bytes.push_back(8'hFF); tx_bytes.push_back(8'hBF);
        // ESC not followed by a bracket
        tx_bytes.push_back(CH_ESC); put_str("X");
        tx_bytes.push_back(CH_ESC); tx_bytes.push_back(CH_ESC); put_str("Y");
        // CSI moves, erases, colors, overflow, intermediates, aborts
        put_csi("A");      put_csi("0B");      put_csi("65535C"); put_csi("99999D");
        put_csi("J");      put_csi("2J");      put_csi("2;1J");
        put_csi("K");      put_csi("1K");      put_csi("7K");
        put_csi("31m");    put_csi("m");       put_csi(";32m");
        put_csi("1;2;3;4;5;6;7;94m");
        put_csi("1;2;3;4;5;6;7;8;9;35m");
        put_csi("?25h");   put_csi(" 5A");     put_csi("3!A");
        put_csi("97m");    put_csi("90m");     put_csi("30m");
        put_csi("37m");    put_csi("38;5m");   put_csi("39m");
        put_str("Z");
        wait_drained();

        // Minimum tab width; receiver holds off while the sender keeps going
        write_tab(8'd1);
        idle_on = 1'b1;
        repeat (40) tx_bytes.push_back(8'($urandom_range(CH_SPACE, FINAL_HI)));
        run_random(100);
        hold_req++;
        wait_drained();

        // Maximum tab width, no idling
        write_tab(8'd255);
        idle_on = 1'b0;
        run_random(100);
        wait_drained();

        // Zero tab width acts as one
        write_tab(8'd0);
        idle_on = 1'b1;
        run_random(80);
        wait_drained();

        mid_tab = 8'($urandom_range(2, 254));
        write_tab(mid_tab);
        run_random(100);
        wait_drained();

        // Last stretch: back to default width, no idling
        write_tab(8'd8);
        idle_on = 1'b0;
        run_random(110);
        wait_drained();

        if (due_cmds.size() != 0)
        begin
            $error("%0d expected results never arrived", due_cmds.size());
            err_count++;
        end
        $display("Sent %0d bytes, checked %0d display commands.", n_bytes, n_cmds);
        $display("Tab widths 8, 1, 255, 0, %0d; UTF-8, CSI, SGR and control bytes.", mid_tab);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Run limit
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Timeout after %0d cycles", LIMIT_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
